// ===== rtl/kceq_pkg.sv =====
// Package for the key change event queue: fixed field widths, key character
// codes and the structs passed between the lanes, the merge stage and the top.
// No dependencies.
package kceq_pkg;

  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [IDX_W-1:0] KEY_UP     = 3'd0;
  localparam logic [IDX_W-1:0] KEY_DN     = 3'd1;
  localparam logic [IDX_W-1:0] KEY_LEFT   = 3'd2;
  localparam logic [IDX_W-1:0] KEY_RIGHT  = 3'd3;
  localparam logic [IDX_W-1:0] KEY_ENTER  = 3'd4;
  localparam logic [IDX_W-1:0] KEY_BACK   = 3'd5;

  localparam logic [CHAR_W-1:0] CHAR_UP    = 8'h69;
  localparam logic [CHAR_W-1:0] CHAR_DOWN  = 8'h6B;
  localparam logic [CHAR_W-1:0] CHAR_LEFT  = 8'h6A;
  localparam logic [CHAR_W-1:0] CHAR_RIGHT = 8'h6C;
  localparam logic [CHAR_W-1:0] CHAR_ENTER = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BACK  = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  typedef struct packed {
    logic down;
    logic chg;
    logic acc;
  } lane_t;

  typedef struct packed {
    logic              event_valid;
    logic [IDX_W-1:0]  key_index;
    logic [CHAR_W-1:0] key_char;
    logic              is_pressed;
  } result_t;

  function automatic logic [CHAR_W-1:0] key_char_of(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      KEY_UP:    c = CHAR_UP;
      KEY_DN:    c = CHAR_DOWN;
      KEY_LEFT:  c = CHAR_LEFT;
      KEY_RIGHT: c = CHAR_RIGHT;
      KEY_ENTER: c = CHAR_ENTER;
      KEY_BACK:  c = CHAR_BACK;
      default:   c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/kceq_in_if.sv =====
// Poll request channel: valid/ready handshake carrying the raw key levels.
// Depends on kceq_pkg.
interface kceq_in_if;
  import kceq_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

// ===== rtl/kceq_out_if.sv =====
// Event result channel: valid/ready handshake carrying one reported event.
// Depends on kceq_pkg.
interface kceq_out_if;
  import kceq_pkg::*;

  logic              valid;
  logic              ready;
  logic              event_valid;
  logic [IDX_W-1:0]  key_index;
  logic [CHAR_W-1:0] key_char;
  logic              is_pressed;

  modport source (output valid, output event_valid, output key_index, output key_char,
                  output is_pressed, input ready);
  modport sink   (input valid, input event_valid, input key_index, input key_char,
                  input is_pressed, output ready);
endinterface

// ===== rtl/kceq_lane.sv =====
// One key lane: derives the down state, the change against the remembered
// state and whether the change still fits in the queue. Depends on kceq_pkg.
module kceq_lane #(
  parameter int NUM_KEYS    = 6,
  parameter int QUEUE_DEPTH = 12,
  parameter int LANE_IDX    = 0
) (
  input  logic [kceq_pkg::LEVEL_W-1:0] levels_i,
  input  logic                         state_i,
  input  logic [NUM_KEYS-1:0]          chg_vec_i,
  output kceq_pkg::lane_t              lane_o
);
  import kceq_pkg::*;

  localparam int RANK_W = $clog2(NUM_KEYS + 1);

  logic              down;
  logic [RANK_W-1:0] rank;

  if (LANE_IDX < LEVEL_W) begin : g_pin
    assign down = ~levels_i[LANE_IDX];
  end else begin : g_nopin
    assign down = 1'b0;
  end

  // count earlier changed keys to find this change's queue position
  always_comb begin
    rank = '0;
    for (int j = 0; j < NUM_KEYS; j++) begin
      if (j < LANE_IDX) begin
        rank = rank + RANK_W'(chg_vec_i[j]);
      end
    end
  end

  assign lane_o.down = down;
  assign lane_o.chg  = down ^ state_i;
  assign lane_o.acc  = (down ^ state_i) && (int'(rank) < QUEUE_DEPTH);

endmodule

// ===== rtl/kceq_merge.sv =====
// Merge stage: picks the lowest queued key, builds the event and returns the
// remaining queued keys. Depends on kceq_pkg.
module kceq_merge #(
  parameter int NUM_KEYS = 6
) (
  input  logic                  fire_i,
  input  logic [NUM_KEYS-1:0]   cand_i,
  input  logic [NUM_KEYS-1:0]   press_i,
  output kceq_pkg::result_t     res_o,
  output logic [NUM_KEYS-1:0]   rest_o
);
  import kceq_pkg::*;

  logic [NUM_KEYS-1:0] first;
  logic [IDX_W-1:0]    idx;

  assign first  = cand_i & (~cand_i + NUM_KEYS'(1));
  assign rest_o = cand_i & ~first;

  always_comb begin
    idx = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (first[k]) begin
        idx = idx | IDX_W'(k);
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (fire_i && (|cand_i)) begin
      res_o.event_valid = 1'b1;
      res_o.key_index   = idx;
      res_o.key_char    = key_char_of(idx);
      res_o.is_pressed  = |(first & press_i);
    end
  end

endmodule

// ===== rtl/key_change_event_queue_core.sv =====
// Key change event queue, top level. Depends on kceq_pkg, kceq_in_if,
// kceq_out_if, kceq_lane and kceq_merge.
//
// Usage: each poll request on evt_in_i carries the raw active-low key levels.
// Every accepted poll yields exactly one result on evt_out_o. A poll right
// after a reported event only clears the yield flag and returns an empty
// result. Otherwise queued changes are popped oldest first; when nothing is
// queued, all keys are checked at once in parallel lanes, changes are queued
// in key order (up to QUEUE_DEPTH) and the lowest one is reported at once.
// Queued events are kept as a per-key pending mask; key index order equals
// queue order, so the mask replaces the event ring.
// Latency: the result is valid in the cycle after poll acceptance. Throughput:
// one poll per cycle when not stalled, set by the single lane-and-merge pass
// between registers. The result sits in an output register; a new poll is
// taken in the same cycle as the pending result leaves. If the receiver
// stalls, the result holds and the poll channel stalls with it.
// Reset: all keys released, no events queued, yield flag cleared, no result.
module key_change_event_queue_core #(
  parameter int NUM_KEYS    = 6,
  parameter int QUEUE_DEPTH = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kceq_in_if.sink           evt_in_i,
  kceq_out_if.source        evt_out_o
);
  import kceq_pkg::*;

  logic [NUM_KEYS-1:0] state_q, state_d;
  logic [NUM_KEYS-1:0] pend_q, pend_d;
  logic                yield_q, yield_d;
  logic                out_vld_q;
  result_t             res_q;

  lane_t               lanes [NUM_KEYS];
  logic [NUM_KEYS-1:0] chg_vec;
  logic [NUM_KEYS-1:0] acc_vec;
  logic [NUM_KEYS-1:0] cand;
  logic [NUM_KEYS-1:0] press;
  logic [NUM_KEYS-1:0] rest;
  logic                scan;
  logic                accept;
  result_t             res;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kceq_lane #(
      .NUM_KEYS    (NUM_KEYS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LANE_IDX    (k)
    ) u_lane (
      .levels_i  (evt_in_i.key_levels),
      .state_i   (state_q[k]),
      .chg_vec_i (chg_vec),
      .lane_o    (lanes[k])
    );
    assign chg_vec[k] = lanes[k].chg;
    assign acc_vec[k] = lanes[k].acc;
  end

  assign scan  = !yield_q && (pend_q == '0);
  assign cand  = scan ? acc_vec : pend_q;
  assign press = scan ? (state_q ^ acc_vec) : state_q;

  kceq_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .fire_i  (!yield_q),
    .cand_i  (cand),
    .press_i (press),
    .res_o   (res),
    .rest_o  (rest)
  );

  assign evt_in_i.ready = !out_vld_q || evt_out_o.ready;
  assign accept         = evt_in_i.valid && evt_in_i.ready;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    yield_d = yield_q;
    if (accept) begin
      if (yield_q) begin
        yield_d = 1'b0;
      end else begin
        if (scan) begin
          state_d = state_q ^ acc_vec;
        end
        pend_d  = rest;
        yield_d = res.event_valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      pend_q    <= '0;
      yield_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      yield_q <= yield_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (evt_out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign evt_out_o.valid       = out_vld_q;
  assign evt_out_o.event_valid = res_q.event_valid;
  assign evt_out_o.key_index   = res_q.key_index;
  assign evt_out_o.key_char    = res_q.key_char;
  assign evt_out_o.is_pressed  = res_q.is_pressed;

endmodule
